>>> rtl/core/nibble_packet_boot_loader_core_defines.svh
// ----------------------------------------------------------------------------
// nibble_packet_boot_loader_core_defines
// Assertion macros shared by the loader core modules.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_PACKET_BOOT_LOADER_CORE_DEFINES_SVH
`define NIBBLE_PACKET_BOOT_LOADER_CORE_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define NPBL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define NPBL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/npbl_pkg.sv
// ----------------------------------------------------------------------------
// npbl_pkg
// Types and constants of the nibble packet boot loader core.
// ----------------------------------------------------------------------------
package npbl_pkg;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    localparam logic       CFG_HEADER = 1'b0;
    localparam logic       CFG_MAGIC  = 1'b1;

    localparam logic [15:0] HEADER_RESET = 16'h0054;
    localparam logic [15:0] MAGIC_RESET  = 16'hCEBA;

    localparam logic [15:0] CMD_LOAD = 16'd1;
    localparam logic [15:0] CMD_EXEC = 16'd2;

    localparam logic [1:0] REP_NONE = 2'd0;
    localparam logic [1:0] REP_LOAD = 2'd1;
    localparam logic [1:0] REP_EXEC = 2'd2;

    typedef enum logic [1:0] {
        OP_START,
        OP_DATA,
        OP_END,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] nib;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_MAGIC,
        PH_LO,
        PH_HI,
        PH_FOOTER
    } phase_t;

endpackage

>>> rtl/core/nibble_packet_boot_loader_core.sv
// ----------------------------------------------------------------------------
// nibble_packet_boot_loader_core
// Takes one packet event beat per clock while in_stall is low and returns one
// result beat for each. A beat passes the two-entry input queue and then the
// result register before its result is presented; with out_stall low the core
// sustains one beat per cycle, and in_stall rises only once the queue holds
// two beats behind a stalled result register.
// Configuration writes take effect at the next clock edge.
// ----------------------------------------------------------------------------
module nibble_packet_boot_loader_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [3:0]  nibble,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        write_valid,
    output logic [15:0] write_addr,
    output logic [7:0]  write_byte,
    output logic [1:0]  report,
    output logic [15:0] report_addr,
    output logic [15:0] report_len,
    input  logic        cfg_wen,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    npbl_pkg::qhead_t head;
    logic             pop;

    npbl_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .nibble   (nibble),
        .head     (head),
        .pop      (pop)
    );

    npbl_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .write_valid (write_valid),
        .write_addr  (write_addr),
        .write_byte  (write_byte),
        .report      (report),
        .report_addr (report_addr),
        .report_len  (report_len)
    );

endmodule

>>> rtl/core/npbl_front.sv
// ----------------------------------------------------------------------------
// npbl_front
// Accepts input beats, decodes the action and queues them for the back end.
// ----------------------------------------------------------------------------
`include "nibble_packet_boot_loader_core_defines.svh"

module npbl_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      action,
    input  logic [3:0]      nibble,
    output npbl_pkg::qhead_t head,
    input  logic            pop
);

    npbl_pkg::item_t q_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      cnt_reg;
    logic [1:0]      cnt_next;
    logic            push;
    npbl_pkg::item_t item_in;

    always_comb
    begin
        case (action)
            npbl_pkg::ACT_START: item_in.op = npbl_pkg::OP_START;
            npbl_pkg::ACT_DATA:  item_in.op = npbl_pkg::OP_DATA;
            npbl_pkg::ACT_END:   item_in.op = npbl_pkg::OP_END;
            default:             item_in.op = npbl_pkg::OP_NONE;
        endcase
        item_in.nib = nibble;
    end

    assign in_stall   = (cnt_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

    `NPBL_ASSERT_ALWAYS(a_pop_needs_item, !(pop && !head.valid), "pop from empty queue")
    `NPBL_ASSERT_NEXT(a_push_shows_head, push && (cnt_reg == 2'd0), head.valid, "pushed beat lost")

endmodule

>>> rtl/core/npbl_back.sv
// ----------------------------------------------------------------------------
// npbl_back
// Packet state machine, configuration registers and result register.
// ----------------------------------------------------------------------------
`include "nibble_packet_boot_loader_core_defines.svh"

module npbl_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  npbl_pkg::qhead_t head,
    output logic             pop,
    input  logic             cfg_wen,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             write_valid,
    output logic [15:0]      write_addr,
    output logic [7:0]       write_byte,
    output logic [1:0]       report,
    output logic [15:0]      report_addr,
    output logic [15:0]      report_len
);

    npbl_pkg::phase_t phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] base_reg, base_next;
    logic [15:0] bcnt_reg, bcnt_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [3:0]  held_reg, held_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] hdr_cfg_reg;
    logic [15:0] magic_cfg_reg;

    logic        out_valid_reg, out_valid_next;
    logic        wv_reg, wv_next;
    logic [15:0] wa_reg, wa_next;
    logic [7:0]  wb_reg, wb_next;
    logic [1:0]  rep_reg, rep_next;
    logic [15:0] ra_reg, ra_next;
    logic [15:0] rl_reg, rl_next;

    logic [15:0] pos_inc;
    logic [15:0] bcnt_inc;
    logic [15:0] addr_sum;
    logic [3:0]  want;
    logic [3:0]  nib;

    function automatic logic [15:0] gather(input logic [15:0] dst, input logic [1:0] slot,
                                           input logic [3:0] n);
        logic [15:0] r;
        r = (slot == 2'd0) ? 16'd0 : dst;
        r[{slot, 2'b00} +: 4] = n;
        return r;
    endfunction

    assign pop      = head.valid && (!out_valid_reg || !out_stall);
    assign nib      = head.item.nib;
    assign pos_inc  = pos_reg + 16'd1;
    assign bcnt_inc = bcnt_reg + 16'd1;
    assign addr_sum = base_reg + bcnt_reg;
    assign want     = magic_cfg_reg[{pos_reg[1:0], 2'b00} +: 4];

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        base_next  = base_reg;
        bcnt_next  = bcnt_reg;
        cmd_next   = cmd_reg;
        held_next  = held_reg;
        len_next   = len_reg;
        wv_next    = 1'b0;
        wa_next    = 16'd0;
        wb_next    = 8'd0;
        rep_next   = npbl_pkg::REP_NONE;
        ra_next    = 16'd0;
        rl_next    = 16'd0;
        if (pop)
        begin
            case (phase_reg)
                npbl_pkg::PH_IDLE:
                begin
                    if (head.item.op == npbl_pkg::OP_START)
                    begin
                        pos_next   = 16'd0;
                        phase_next = npbl_pkg::PH_HEADER;
                    end
                end
                npbl_pkg::PH_HEADER:
                begin
                    if (head.item.op == npbl_pkg::OP_END)
                    begin
                        phase_next = npbl_pkg::PH_IDLE;
                    end
                    else if (head.item.op == npbl_pkg::OP_DATA)
                    begin
                        pos_next = pos_inc;
                        if (pos_inc == hdr_cfg_reg)
                        begin
                            phase_next = npbl_pkg::PH_MAGIC;
                            pos_next   = 16'd0;
                            base_next  = 16'd0;
                            len_next   = 16'd0;
                            cmd_next   = 16'd0;
                        end
                    end
                end
                npbl_pkg::PH_MAGIC:
                begin
                    if (head.item.op == npbl_pkg::OP_END)
                    begin
                        phase_next = npbl_pkg::PH_IDLE;
                    end
                    else if (head.item.op == npbl_pkg::OP_DATA)
                    begin
                        pos_next = pos_inc;
                        case (pos_reg[3:2])
                            2'd0:
                            begin
                                if (nib != want)
                                begin
                                    phase_next = npbl_pkg::PH_FOOTER;
                                end
                            end
                            2'd1:    cmd_next  = gather(cmd_reg, pos_reg[1:0], nib);
                            2'd2:    base_next = gather(base_reg, pos_reg[1:0], nib);
                            default:
                            begin
                                if (pos_reg[1:0] == 2'd0)
                                begin
                                    if (cmd_reg == npbl_pkg::CMD_LOAD)
                                    begin
                                        len_next = {12'd0, nib};
                                    end
                                    else
                                    begin
                                        phase_next = npbl_pkg::PH_FOOTER;
                                    end
                                end
                                else
                                begin
                                    len_next = gather(len_reg, pos_reg[1:0], nib);
                                    if (pos_reg[1:0] == 2'd3)
                                    begin
                                        phase_next = npbl_pkg::PH_LO;
                                        bcnt_next  = 16'd0;
                                        pos_next   = pos_reg;
                                    end
                                end
                            end
                        endcase
                    end
                end
                npbl_pkg::PH_LO:
                begin
                    if (head.item.op == npbl_pkg::OP_END)
                    begin
                        phase_next = npbl_pkg::PH_IDLE;
                    end
                    else if (head.item.op == npbl_pkg::OP_DATA)
                    begin
                        wv_next    = 1'b1;
                        wa_next    = addr_sum;
                        wb_next    = {4'd0, nib};
                        held_next  = nib;
                        phase_next = npbl_pkg::PH_HI;
                    end
                end
                npbl_pkg::PH_HI:
                begin
                    if (head.item.op == npbl_pkg::OP_END)
                    begin
                        phase_next = npbl_pkg::PH_IDLE;
                    end
                    else if (head.item.op == npbl_pkg::OP_DATA)
                    begin
                        wv_next    = 1'b1;
                        wa_next    = addr_sum;
                        wb_next    = {nib, held_reg};
                        bcnt_next  = bcnt_inc;
                        phase_next = (bcnt_inc == len_reg) ? npbl_pkg::PH_FOOTER
                                                           : npbl_pkg::PH_LO;
                    end
                end
                npbl_pkg::PH_FOOTER:
                begin
                    if (head.item.op == npbl_pkg::OP_END)
                    begin
                        if (cmd_reg == npbl_pkg::CMD_LOAD)
                        begin
                            rep_next = npbl_pkg::REP_LOAD;
                            ra_next  = base_reg;
                            rl_next  = len_reg;
                        end
                        else if (cmd_reg == npbl_pkg::CMD_EXEC)
                        begin
                            rep_next = npbl_pkg::REP_EXEC;
                            ra_next  = base_reg;
                        end
                        phase_next = npbl_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = npbl_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= npbl_pkg::PH_IDLE;
            pos_reg       <= 16'd0;
            base_reg      <= 16'd0;
            bcnt_reg      <= 16'd0;
            cmd_reg       <= 16'd0;
            held_reg      <= 4'd0;
            len_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            base_reg      <= base_next;
            bcnt_reg      <= bcnt_next;
            cmd_reg       <= cmd_next;
            held_reg      <= held_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cfg_reg   <= npbl_pkg::HEADER_RESET;
            magic_cfg_reg <= npbl_pkg::MAGIC_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                npbl_pkg::CFG_HEADER: hdr_cfg_reg   <= cfg_data;
                npbl_pkg::CFG_MAGIC:  magic_cfg_reg <= cfg_data;
                default:              hdr_cfg_reg   <= hdr_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            wv_reg  <= wv_next;
            wa_reg  <= wa_next;
            wb_reg  <= wb_next;
            rep_reg <= rep_next;
            ra_reg  <= ra_next;
            rl_reg  <= rl_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_valid = wv_reg;
    assign write_addr  = wa_reg;
    assign write_byte  = wb_reg;
    assign report      = rep_reg;
    assign report_addr = ra_reg;
    assign report_len  = rl_reg;

    `NPBL_ASSERT_ALWAYS(a_data_is_load, !((phase_reg == npbl_pkg::PH_LO || phase_reg == npbl_pkg::PH_HI) && (cmd_reg != npbl_pkg::CMD_LOAD)), "data phase without load command")
    `NPBL_ASSERT_NEXT(a_write_no_report, pop && wv_next, rep_reg == npbl_pkg::REP_NONE, "write and report in one beat")

endmodule
